// ===== hw/rtl/fol_pkg.sv =====
// Shared types and constants of the frequency ordered lookup table.
// No dependencies; imported by fol_ram and frequency_ordered_lookup_table.
package fol_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 16;
   localparam int POS_W   = 6;
   localparam int ENTRY_W = VALUE_W + COUNT_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_LOCATE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_MISS  = 2'd2;
   localparam logic [1:0] STATUS_FULL  = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_MOVE,
      S_PLACE
   } state_type;

endpackage

// ===== hw/rtl/fol_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on fol_pkg only through the common import convention.
module fol_ram
   import fol_pkg::*;
#(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/frequency_ordered_lookup_table.sv =====
// Frequency ordered lookup table: ordered value table with access counts.
// Depends on fol_pkg and fol_ram.
//
// Usage: requests arrive on req_* (req_tuser = request code, req_tdata = value).
// Clear empties the table, append adds a value at the tail with count 0, locate
// finds the first equal entry, bumps its saturating count and moves it toward the
// head past every earlier entry with a strictly smaller count. Every request
// returns one transfer on rsp_* (rsp_tuser = status, rsp_tdata = position, count).
// Clear, append, an unused code and a locate on an empty table answer straight from idle.
// A locate walks the entry RAM through its single read port: it scans the entries
// from the head up to the hit, then compares the earlier entries on the way back
// and writes the found entry at its new place; a miss scans all stored entries.
// The block takes one request at a time; req_tready is low while a locate runs.
// The result sits in an output register; a new request is taken while that
// register drains, and a stalled receiver holds the result and blocks new requests.
// Reset empties the table at once; stored entries need no clearing pass.
module frequency_ordered_lookup_table
   import fol_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_tuser,   // [1:0] req_type
   input  logic signed [31:0] req_tdata,   // [31:0] value
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [1:0]         rsp_tuser,   // [1:0] status
   output logic [23:0]        rsp_tdata    // [5:0] position, [21:6] hit_count, [23:22] zero
);

   localparam int AW = $clog2(DEPTH);
   localparam int TW = $clog2(DEPTH + 1);

   state_type state_ff, state_in;

   logic [TW-1:0]      total_ff, total_in;
   logic [TW-1:0]      scan_ff, scan_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]   rsp_position_ff, rsp_position_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   logic               req_fire;
   logic               rsp_free;
   logic               res_load;
   logic [VALUE_W-1:0] rd_value;
   logic [COUNT_W-1:0] rd_count;
   logic [COUNT_W-1:0] cnt_next;
   logic               hit;
   logic               last_rd;
   logic               shift;

   fol_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && rsp_free;
   assign req_fire   = req_tvalid && req_tready;

   assign rd_value = rd_data[VALUE_W-1:0];
   assign rd_count = rd_data[ENTRY_W-1:VALUE_W];
   assign cnt_next = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_W'(1);
   assign hit      = rd_vld_ff && (rd_value == key_ff);
   assign last_rd  = TW'(rd_idx_ff) == (total_ff - TW'(1));
   assign shift    = rd_count < cnt_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_tuser == REQ_LOCATE && total_ff != '0) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (hit) begin
               state_in = (rd_idx_ff == '0) ? S_PLACE : S_MOVE;
            end else if (rd_vld_ff && last_rd) begin
               state_in = S_IDLE;
            end
         end
         S_MOVE: begin
            if (!shift || pos_ff <= AW'(1)) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      total_in        = total_ff;
      scan_in         = scan_ff;
      rd_vld_in       = 1'b0;
      rd_idx_in       = rd_idx_ff;
      pos_in          = pos_ff;
      key_in          = key_ff;
      cnt_in          = cnt_ff;
      wr_en           = 1'b0;
      wr_addr         = pos_ff;
      wr_data         = {cnt_ff, key_ff};
      rd_addr         = scan_ff[AW-1:0];
      res_load        = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_load        = 1'b1;
               rsp_status_in   = STATUS_OK;
               rsp_position_in = '0;
               rsp_count_in    = '0;
               case (req_tuser)
                  REQ_CLEAR: begin
                     total_in = '0;
                  end
                  REQ_APPEND: begin
                     if (total_ff == TW'(DEPTH)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        wr_en           = 1'b1;
                        wr_addr         = total_ff[AW-1:0];
                        wr_data         = {{COUNT_W{1'b0}}, req_tdata};
                        total_in        = total_ff + TW'(1);
                        rsp_position_in = POS_W'(total_ff);
                     end
                  end
                  REQ_LOCATE: begin
                     if (total_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        res_load  = 1'b0;
                        key_in    = req_tdata;
                        rd_addr   = '0;
                        rd_vld_in = 1'b1;
                        rd_idx_in = '0;
                        scan_in   = TW'(1);
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SEARCH: begin
            if (hit) begin
               cnt_in = cnt_next;
               pos_in = rd_idx_ff;
               if (rd_idx_ff != '0) begin
                  rd_addr   = rd_idx_ff - AW'(1);
                  rd_vld_in = 1'b1;
               end
            end else if (rd_vld_ff && last_rd) begin
               res_load        = 1'b1;
               rsp_status_in   = STATUS_MISS;
               rsp_position_in = '0;
               rsp_count_in    = '0;
            end else if (scan_ff < total_ff) begin
               rd_addr   = scan_ff[AW-1:0];
               rd_vld_in = 1'b1;
               rd_idx_in = scan_ff[AW-1:0];
               scan_in   = scan_ff + TW'(1);
            end
         end
         S_MOVE: begin
            if (shift) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = rd_data;
               pos_in  = pos_ff - AW'(1);
               if (pos_ff > AW'(1)) begin
                  rd_addr   = pos_ff - AW'(2);
                  rd_vld_in = 1'b1;
               end
            end
         end
         S_PLACE: begin
            if (rsp_free) begin
               wr_en           = 1'b1;
               res_load        = 1'b1;
               rsp_status_in   = STATUS_OK;
               rsp_position_in = POS_W'(pos_ff);
               rsp_count_in    = cnt_ff;
            end
         end
         default: ;
      endcase
      rsp_valid_in = res_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff         <= scan_in;
      rd_idx_ff       <= rd_idx_in;
      pos_ff          <= pos_in;
      key_ff          <= key_in;
      cnt_ff          <= cnt_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_position_ff};

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_load |-> rsp_free)
      else $error("result loaded over an untaken result");

   a_total_in_range: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TW'(DEPTH))
      else $error("entry total beyond depth");

   a_locate_starts_search: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == REQ_LOCATE && total_ff != '0) |=> state_ff == S_SEARCH)
      else $error("locate did not start a search");

   a_move_has_data: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MOVE |-> rd_vld_ff)
      else $error("move step without read data");

endmodule
